// ===== hdl/bra_pkg.sv =====
// Package for the bitmap run allocator: command codes, fixed field widths and constants.
// No dependencies; imported by the word evaluator and the top level.
package bra_pkg;

  // Command codes on in_cmd
  typedef enum logic [1:0] {
    CMD_FIND  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_TEST  = 2'd3
  } cmd_t;

  // Fixed payload widths
  localparam int START_W = 11;
  localparam int LEN_W   = 12;
  localparam int WIU_W   = 7;

  // Reset value of the words-in-use register
  localparam logic [WIU_W-1:0] WIU_RESET = 7'd64;

  // Run-length counter saturates here (any value >= the largest length will do)
  localparam logic [LEN_W-1:0] RUN_MAX = 12'hFFF;

  // Shift used for the reciprocal divide of the start bit by the word size
  localparam int RECIP_SH = 16;

endpackage

// ===== hdl/bitmap_run_allocator.sv =====
// Top level of the bitmap run allocator: command sequencer around the map RAM.
// Depends on bra_pkg, bra_ram and bra_word_eval.
//
//  channel   ports                                  handshake
//  --------  -------------------------------------  -----------------------------
//  command   in_cmd, in_bit_index, in_length         start high while busy low
//  result    out_hit, out_run_start                  out_valid, one cycle, no stall
//  config    cfg_wdata                               cfg_we, written at once
//
// A command passes the divide and setup states and the registered RAM read, then
// walks one map word a cycle, set by the single RAM read port, to the last live
// word. Range commands finish at the last word of the range, a test also at a
// clear bit, searches at the hit. After reset the map RAM is cleared one word a
// cycle with busy high; configuration writes are taken during that pass.
// Results are shown for one cycle on out_valid; the receiver cannot stall.
module bitmap_run_allocator
  import bra_pkg::*;
#(
  parameter int WORDS     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic [START_W-1:0] in_bit_index,
  input  logic [LEN_W-1:0]   in_length,
  output logic               out_valid,
  output logic               out_hit,
  output logic [START_W-1:0] out_run_start,
  input  logic               cfg_we,
  input  logic [WIU_W-1:0]   cfg_wdata
);

  localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W  = $clog2(WORDS + 1);
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int OFF_W  = BIT_W + 2;
  localparam int TOT_W  = $clog2(WORDS * WORD_BITS + 1);
  localparam int NWC_W  = (CNT_W > WIU_W) ? CNT_W : WIU_W;
  localparam int QC_W   = ((CNT_W > START_W) ? CNT_W : START_W) + 1;
  localparam int CMP_W  = ((TOT_W > LEN_W) ? TOT_W : LEN_W) + 2;
  localparam int MUL_W  = START_W + BIT_W + 2;
  localparam int PRD_W  = START_W + RECIP_SH + 1;
  localparam int RECIP  = (1 << RECIP_SH) / WORD_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_SCAN
  } state_t;

  state_t             state_r;
  logic [WIU_W-1:0]   wiu_r;
  logic [WIDX_W-1:0]  clr_idx_r;
  cmd_t               cmd_r;
  logic [START_W-1:0] start_r;
  logic [LEN_W-1:0]   len_r;
  logic [START_W-1:0] q0_r;
  logic [WIDX_W-1:0]  rd_idx_r;
  logic               iss_r;
  logic               iss_first_r;
  logic               pv_r;
  logic               pf_r;
  logic               pl_r;
  logic [WIDX_W-1:0]  pw_idx_r;
  logic [TOT_W-1:0]   base_r;
  logic [BIT_W-1:0]   off_r;
  logic [LEN_W-1:0]   cur_r;
  logic [TOT_W-1:0]   rs_r;
  logic [LEN_W-1:0]   rem_r;
  logic               out_valid_r;
  logic               out_hit_r;
  logic [START_W-1:0] out_run_start_r;

  // Live word count and bit total
  logic [NWC_W-1:0] wiu_ext;
  logic [CNT_W-1:0] nwords;
  logic [CNT_W-1:0] nwords_m1;
  logic [TOT_W-1:0] total;

  always_comb begin
    wiu_ext   = NWC_W'(wiu_r);
    nwords    = (wiu_ext > NWC_W'(WORDS)) ? CNT_W'(WORDS) : CNT_W'(wiu_ext);
    nwords_m1 = nwords - CNT_W'(1);
    total     = TOT_W'(nwords) * TOT_W'(WORD_BITS);
  end

  // Start word by reciprocal multiply, corrected in the setup cycle
  logic [PRD_W-1:0]   q_prod;
  logic [MUL_W-1:0]   q_mul;
  logic [MUL_W-1:0]   r_diff;
  logic [OFF_W-1:0]   r0;
  logic               r_corr;
  logic [START_W-1:0] q_fix;
  logic [BIT_W-1:0]   off_fix;
  logic [TOT_W-1:0]   base_fix;
  logic               beyond;
  logic               past_end;

  always_comb begin
    q_prod   = PRD_W'(start_r) * PRD_W'(RECIP);
    q_mul    = MUL_W'(q0_r) * MUL_W'(WORD_BITS);
    r_diff   = MUL_W'(start_r) - q_mul;
    r0       = r_diff[OFF_W-1:0];
    r_corr   = (r0 >= OFF_W'(WORD_BITS));
    q_fix    = r_corr ? (q0_r + START_W'(1)) : q0_r;
    off_fix  = r_corr ? BIT_W'(r0 - OFF_W'(WORD_BITS)) : BIT_W'(r0);
    base_fix = r_corr ? TOT_W'(q_mul + MUL_W'(WORD_BITS)) : TOT_W'(q_mul);
    beyond   = (QC_W'(q_fix) >= QC_W'(nwords));
    past_end = ((CMP_W'(start_r) + CMP_W'(len_r)) > CMP_W'(total));
  end

  // Map RAM
  logic                 ram_we;
  logic [WIDX_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] ev_wr_data;

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_r == ST_SCAN) && pv_r && ((cmd_r == CMD_SET) || (cmd_r == CMD_CLEAR));
      ram_waddr = pw_idx_r;
      ram_wdata = ev_wr_data;
    end
  end

  bra_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (iss_r),
    .raddr(rd_idx_r),
    .rdata(ram_rdata)
  );

  // Word evaluator on the read data
  logic             ev_all_set;
  logic [LEN_W-1:0] ev_used;
  logic             ev_found;
  logic [TOT_W-1:0] ev_found_start;
  logic [LEN_W-1:0] ev_cur_nxt;
  logic [TOT_W-1:0] ev_rs_nxt;

  bra_word_eval #(
    .WORD_BITS(WORD_BITS),
    .TOT_W    (TOT_W)
  ) u_eval (
    .data       (ram_rdata),
    .first      (pf_r),
    .off        (off_r),
    .base       (base_r),
    .cur        (cur_r),
    .rs         (rs_r),
    .len        (len_r),
    .rem        (rem_r),
    .cmd        (cmd_r),
    .wr_data    (ev_wr_data),
    .all_set    (ev_all_set),
    .used       (ev_used),
    .found      (ev_found),
    .found_start(ev_found_start),
    .cur_nxt    (ev_cur_nxt),
    .rs_nxt     (ev_rs_nxt)
  );

  // Finish decision for the word being processed
  logic               fin;
  logic               fin_hit;
  logic [START_W-1:0] fin_start;

  always_comb begin
    fin       = 1'b0;
    fin_hit   = 1'b0;
    fin_start = '0;
    case (cmd_r)
      CMD_FIND: begin
        if (ev_found) begin
          fin       = 1'b1;
          fin_hit   = 1'b1;
          fin_start = START_W'(ev_found_start);
        end else if (pl_r) begin
          fin = 1'b1;
        end
      end
      CMD_SET, CMD_CLEAR: begin
        fin = (rem_r == ev_used) || pl_r;
      end
      CMD_TEST: begin
        if (!ev_all_set) begin
          fin = 1'b1;
        end else if (rem_r == ev_used) begin
          fin     = 1'b1;
          fin_hit = 1'b1;
        end else if (pl_r) begin
          fin = 1'b1;
        end
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  // Sequencer, read pipeline and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      wiu_r       <= WIU_RESET;
      clr_idx_r   <= '0;
      iss_r       <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        wiu_r <= cfg_wdata;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + WIDX_W'(1);
          if (clr_idx_r == WIDX_W'(WORDS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            cmd_r   <= cmd_t'(in_cmd);
            start_r <= in_bit_index;
            len_r   <= in_length;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          q0_r    <= q_prod[RECIP_SH +: START_W];
          state_r <= ST_SETUP;
        end
        ST_SETUP: begin
          rd_idx_r    <= WIDX_W'(q_fix);
          iss_first_r <= 1'b1;
          pv_r        <= 1'b0;
          base_r      <= base_fix;
          off_r       <= off_fix;
          cur_r       <= '0;
          rs_r        <= '0;
          rem_r       <= len_r;
          if ((cmd_r == CMD_FIND && beyond) ||
              ((cmd_r == CMD_SET || cmd_r == CMD_CLEAR) && (beyond || len_r == '0)) ||
              (cmd_r == CMD_TEST && (len_r == '0 || past_end))) begin
            out_valid_r     <= 1'b1;
            out_hit_r       <= 1'b0;
            out_run_start_r <= '0;
            state_r         <= ST_IDLE;
          end else begin
            iss_r   <= 1'b1;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Read issue, one word a cycle up to the last live word
          pv_r <= iss_r;
          if (iss_r) begin
            pw_idx_r    <= rd_idx_r;
            pf_r        <= iss_first_r;
            pl_r        <= (CNT_W'(rd_idx_r) == nwords_m1);
            iss_first_r <= 1'b0;
            rd_idx_r    <= rd_idx_r + WIDX_W'(1);
            if (CNT_W'(rd_idx_r) == nwords_m1) begin
              iss_r <= 1'b0;
            end
          end
          // Word processing
          if (pv_r) begin
            base_r <= base_r + TOT_W'(WORD_BITS);
            cur_r  <= ev_cur_nxt;
            rs_r   <= ev_rs_nxt;
            rem_r  <= rem_r - ev_used;
            if (fin) begin
              iss_r           <= 1'b0;
              pv_r            <= 1'b0;
              out_valid_r     <= 1'b1;
              out_hit_r       <= fin_hit;
              out_run_start_r <= fin_start;
              state_r         <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_run_start = out_run_start_r;

endmodule

// ===== hdl/bra_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds the allocator's bit map.
module bra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bra_word_eval.sv =====
// Per-word evaluation for the bitmap run allocator: range masks, run search.
// Depends on bra_pkg; instantiated by bitmap_run_allocator.
module bra_word_eval
  import bra_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int TOT_W     = 12
) (
  input  logic [WORD_BITS-1:0]         data,
  input  logic                         first,
  input  logic [$clog2(WORD_BITS)-1:0] off,
  input  logic [TOT_W-1:0]             base,
  input  logic [LEN_W-1:0]             cur,
  input  logic [TOT_W-1:0]             rs,
  input  logic [LEN_W-1:0]             len,
  input  logic [LEN_W-1:0]             rem,
  input  cmd_t                         cmd,
  output logic [WORD_BITS-1:0]         wr_data,
  output logic                         all_set,
  output logic [LEN_W-1:0]             used,
  output logic                         found,
  output logic [TOT_W-1:0]             found_start,
  output logic [LEN_W-1:0]             cur_nxt,
  output logic [TOT_W-1:0]             rs_nxt
);

  localparam int BIT_W = $clog2(WORD_BITS);
  localparam int OFF_W = BIT_W + 2;
  localparam int RL_W  = LEN_W + 1;

  logic [OFF_W-1:0]     lo;
  logic [OFF_W-1:0]     hi;
  logic [LEN_W-1:0]     avail;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] eff;

  // Range mask: bits lo .. lo+used-1 of this word
  always_comb begin
    lo    = first ? OFF_W'(off) : '0;
    avail = LEN_W'(WORD_BITS) - LEN_W'(lo);
    used  = (rem < avail) ? rem : avail;
    hi    = lo + OFF_W'(used);
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j] = (OFF_W'(j) >= lo) && (OFF_W'(j) < hi);
    end
    wr_data = (cmd == CMD_SET) ? (data | mask) : (data & ~mask);
    all_set = ((data & mask) == mask);
  end

  // Run search: each bit finds the last zero at or below it, then the run
  // ending there is either local to the word or continues the carried run.
  always_comb begin
    logic             zs;
    logic             zs_all;
    logic [BIT_W-1:0] zp;
    logic [BIT_W-1:0] zp_all;
    logic [RL_W-1:0]  run_len;
    logic [RL_W-1:0]  sum;
    logic             ok;

    for (int j = 0; j < WORD_BITS; j++) begin
      eff[j] = data[j] && (OFF_W'(j) >= lo);
    end

    found       = 1'b0;
    found_start = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      zs = 1'b0;
      zp = '0;
      for (int k = 0; k < WORD_BITS; k++) begin
        if (k <= j && !eff[k]) begin
          zs = 1'b1;
          zp = BIT_W'(k);
        end
      end
      run_len = zs ? (RL_W'(j) - RL_W'(zp)) : (RL_W'(cur) + RL_W'(j + 1));
      ok      = eff[j] && (run_len >= RL_W'(len));
      if (ok && !found) begin
        found = 1'b1;
        if (zs) begin
          found_start = base + TOT_W'(zp) + TOT_W'(1);
        end else if (cur != '0) begin
          found_start = rs;
        end else begin
          found_start = base;
        end
      end
    end

    // Carry of the run into the next word
    zs_all = 1'b0;
    zp_all = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (!eff[k]) begin
        zs_all = 1'b1;
        zp_all = BIT_W'(k);
      end
    end
    sum = RL_W'(cur) + RL_W'(WORD_BITS);
    if (zs_all) begin
      cur_nxt = LEN_W'(WORD_BITS - 1) - LEN_W'(zp_all);
      rs_nxt  = base + TOT_W'(zp_all) + TOT_W'(1);
    end else begin
      cur_nxt = sum[RL_W-1] ? RUN_MAX : sum[LEN_W-1:0];
      rs_nxt  = (cur != '0) ? rs : base;
    end
  end

endmodule
